// ===== rtl/core/kanji_char_type_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// kanji character type lookup assertion macros
// assertion forms used by the kanji_char_type_lookup rtl
// ----------------------------------------------------------------------------
`ifndef KANJI_CHAR_TYPE_LOOKUP_ASSERT_SVH
`define KANJI_CHAR_TYPE_LOOKUP_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define KCTL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kctl assertion failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define KCTL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kctl assertion failed");

`endif

// ===== rtl/core/kctl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kctl_pkg
// widths, constants, codes and types of the kanji character type lookup
// ----------------------------------------------------------------------------
package kctl_pkg;

   localparam int FONTS   = 4;
   localparam int ENTRIES = 256;

   localparam int FUNC_W  = 2;
   localparam int FONT_W  = 2;
   localparam int SLOT_W  = 8;
   localparam int CODE_W  = 16;
   localparam int TYPE_W  = 8;
   localparam int TOTAL_W = 9;
   localparam int ENTRY_W = CODE_W + TYPE_W;
   localparam int DEPTH   = FONTS * ENTRIES;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SETUP  = 2'd2;

   localparam logic [CODE_W-1:0] EUC_MASK = 16'h7F7F;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FIRST = 5'b00010,
      ST_LAST  = 5'b00100,
      ST_PROBE = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/kctl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kctl_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module kctl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== rtl/core/kanji_char_type_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// lookup path: an empty table or a bad font goes straight to the result register, a
// code outside the table range is settled after the first and last entries are read,
// and any other code runs the binary search over up to 256 entries; one ram read per cycle
// sets the pace, and no new item is taken until the result register is loaded. writes and setups give no result.
// reset clears the sequencer, the output valid flag, counts, defaults and the
// encoding mode; the entry ram is not cleared and is undefined until written.
// ----------------------------------------------------------------------------
// kanji_char_type_lookup
// per-font sorted code table with binary search lookup of the character type
// ----------------------------------------------------------------------------
`include "kanji_char_type_lookup_assert.svh"

module kanji_char_type_lookup (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // configuration write
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic                            csr_encoding_mode,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [kctl_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [kctl_pkg::FONT_W-1:0]     req_font_slot,
   input  wire logic [kctl_pkg::SLOT_W-1:0]     req_entry_slot,
   input  wire logic [kctl_pkg::CODE_W-1:0]     req_char_code,
   input  wire logic [kctl_pkg::TYPE_W-1:0]     req_type_value,
   input  wire logic [kctl_pkg::TOTAL_W-1:0]    req_entry_total,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [kctl_pkg::TYPE_W-1:0]     rsp_char_type,
   output logic                                 rsp_found
);

   import kctl_pkg::*;

   state_type           state_ff, state_in;
   logic                encoding_ff;
   logic [TOTAL_W-1:0]  count_ff [FONTS];
   logic [TYPE_W-1:0]   default_ff [FONTS];

   logic [CODE_W-1:0]   jc_ff, jc_in;
   logic [FONT_W-1:0]   font_ff, font_in;
   logic [SLOT_W-1:0]   last_ff, last_in;
   logic [TYPE_W-1:0]   dflt_ff, dflt_in;
   logic                below_ff, below_in;
   logic [SLOT_W-1:0]   lo_ff, lo_in;
   logic [SLOT_W-1:0]   hi_ff, hi_in;
   logic [SLOT_W-1:0]   mid_ff, mid_in;
   logic [TYPE_W-1:0]   res_type_ff, res_type_in;
   logic                res_found_ff, res_found_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TYPE_W-1:0]   rsp_type_ff, rsp_type_in;
   logic                rsp_found_ff, rsp_found_in;

   logic                req_xfer;
   logic                font_ok;
   logic [TOTAL_W-1:0]  cnt_sel;
   logic [SLOT_W-1:0]   rd_idx;
   logic [FONT_W-1:0]   rd_font;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0]  rd_data;
   logic [CODE_W-1:0]   rd_code;
   logic                wr_en;
   logic [SLOT_W-1:0]   gap;

   // shift-jis to jis, each byte modulo 256
   function automatic logic [CODE_W-1:0] sjis_to_jis(input logic [CODE_W-1:0] c);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = c[15:8];
      lo = c[7:0];
      if (hi <= 8'h9F) begin
         hi = hi - 8'h71;
      end else begin
         hi = hi - 8'hB1;
      end
      hi = {hi[6:0], 1'b1};
      if (lo > 8'h7F) begin
         lo = lo - 8'd1;
      end
      if (lo >= 8'h9E) begin
         lo = lo - 8'h7D;
         hi = hi + 8'd1;
      end else begin
         lo = lo - 8'h1F;
      end
      return {hi, lo};
   endfunction

   assign csr_ready     = 1'b1;
   assign req_stall     = (state_ff != ST_IDLE);
   assign req_xfer      = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_type = rsp_type_ff;
   assign rsp_found     = rsp_found_ff;

   assign font_ok = (int'(req_font_slot) < FONTS);
   assign cnt_sel = count_ff[req_font_slot];
   assign rd_code = rd_data[ENTRY_W-1:TYPE_W];
   assign rd_addr = {rd_font, rd_idx};
   assign wr_en   = req_xfer && (req_func == FUNC_WRITE) && font_ok
                    && (int'(req_entry_slot) < ENTRIES);

   kctl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr ({req_font_slot, req_entry_slot}),
      .wr_data ({req_char_code, req_type_value}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      jc_in        = jc_ff;
      font_in      = font_ff;
      last_in      = last_ff;
      dflt_in      = dflt_ff;
      below_in     = below_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      res_type_in  = res_type_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_type_in  = rsp_type_ff;
      rsp_found_in = rsp_found_ff;
      rd_font      = font_ff;
      rd_idx       = mid_ff;
      gap          = '0;

      case (state_ff)
         ST_IDLE: begin
            rd_font = req_font_slot;
            rd_idx  = '0;
            if (req_xfer && (req_func == FUNC_LOOKUP)) begin
               jc_in   = encoding_ff ? sjis_to_jis(req_char_code)
                                     : (req_char_code & EUC_MASK);
               font_in = req_font_slot;
               dflt_in = default_ff[req_font_slot];
               last_in = SLOT_W'(cnt_sel - TOTAL_W'(1));
               res_found_in = 1'b0;
               if (!font_ok) begin
                  res_type_in = '0;
                  state_in    = ST_DONE;
               end else if (cnt_sel == '0) begin
                  res_type_in = default_ff[req_font_slot];
                  state_in    = ST_DONE;
               end else begin
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            // entry 0 is on the read port, fetch the last entry next
            rd_idx   = last_ff;
            below_in = (jc_ff < rd_code);
            state_in = ST_LAST;
         end
         ST_LAST: begin
            if (below_ff || (jc_ff > rd_code)) begin
               res_type_in  = dflt_ff;
               res_found_in = 1'b0;
               state_in     = ST_DONE;
            end else begin
               lo_in    = '0;
               hi_in    = last_ff;
               mid_in   = last_ff >> 1;
               rd_idx   = mid_in;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            res_type_in  = dflt_ff;
            res_found_in = 1'b0;
            if (jc_ff == rd_code) begin
               res_type_in  = rd_data[TYPE_W-1:0];
               res_found_in = 1'b1;
               state_in     = ST_DONE;
            end else if (jc_ff < rd_code) begin
               if (mid_ff == lo_ff) begin
                  state_in = ST_DONE;
               end else begin
                  hi_in  = mid_ff - SLOT_W'(1);
                  gap    = hi_in - lo_ff;
                  mid_in = lo_ff + (gap >> 1);
               end
            end else begin
               if (mid_ff == hi_ff) begin
                  state_in = ST_DONE;
               end else begin
                  lo_in  = mid_ff + SLOT_W'(1);
                  gap    = hi_ff - lo_in;
                  mid_in = lo_in + (gap >> 1);
               end
            end
            rd_idx = mid_in;
         end
         ST_DONE: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_type_in  = res_type_ff;
               rsp_found_in = res_found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         encoding_ff  <= 1'b0;
         for (int i = 0; i < FONTS; i++) begin
            count_ff[i]   <= '0;
            default_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            encoding_ff <= csr_encoding_mode;
         end
         if (req_xfer && (req_func == FUNC_SETUP) && font_ok) begin
            count_ff[req_font_slot]   <= (int'(req_entry_total) > ENTRIES)
                                         ? TOTAL_W'(ENTRIES) : req_entry_total;
            default_ff[req_font_slot] <= req_type_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      jc_ff        <= jc_in;
      font_ff      <= font_in;
      last_ff      <= last_in;
      dflt_ff      <= dflt_in;
      below_ff     <= below_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_type_ff  <= res_type_in;
      res_found_ff <= res_found_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_found_ff <= rsp_found_in;
   end

   // search window stays ordered around the probe
   `KCTL_ASSERT_NOW(a_probe_window, state_ff == ST_PROBE,
                    (lo_ff <= mid_ff) && (mid_ff <= hi_ff) && (hi_ff <= last_ff))
   // a finished search with a free output register shows its result next cycle
   `KCTL_ASSERT_NEXT(a_done_to_rsp, (state_ff == ST_DONE) && !(rsp_valid_ff && rsp_stall),
                     rsp_valid && (state_ff == ST_IDLE))
   // only a lookup transfer starts the table search
   `KCTL_ASSERT_NOW(a_first_from_lookup, (state_ff == ST_FIRST),
                    $past(req_xfer) && ($past(req_func) == FUNC_LOOKUP))

endmodule

`default_nettype wire

// ===== verif/kanji_char_type_lookup_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kanji_char_type_lookup_test
// loads per-font code tables through write transfers, then checks each lookup
// result against a behavioral copy of the tables and the search, in both input
// encodings and under random sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module kanji_char_type_lookup_test;
   import kctl_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 16;

   typedef struct {
      logic [FUNC_W-1:0]  func;
      logic [FONT_W-1:0]  font;
      logic [SLOT_W-1:0]  slot;
      logic [CODE_W-1:0]  code;
      logic [TYPE_W-1:0]  ctype;
      logic [TOTAL_W-1:0] total;
   } req_item_type;

   typedef struct {
      logic [TYPE_W-1:0] ctype;
      logic              found;
   } rsp_item_type;

   typedef struct {
      logic [TYPE_W-1:0] ctype;
      logic              found;
      bit                safe;
   } match_type;

   typedef struct {
      bit           sjis;
      req_item_type it;
      bit           typed;
      rsp_item_type want;
   } row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_encoding_mode = 1'b0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = '0;
   logic [FONT_W-1:0]   req_font_slot = '0;
   logic [SLOT_W-1:0]   req_entry_slot = '0;
   logic [CODE_W-1:0]   req_char_code = '0;
   logic [TYPE_W-1:0]   req_type_value = '0;
   logic [TOTAL_W-1:0]  req_entry_total = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TYPE_W-1:0]   rsp_char_type;
   logic                rsp_found;

   kanji_char_type_lookup u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_encoding_mode (csr_encoding_mode),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_font_slot     (req_font_slot),
      .req_entry_slot    (req_entry_slot),
      .req_char_code     (req_char_code),
      .req_type_value    (req_type_value),
      .req_entry_total   (req_entry_total),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_char_type     (rsp_char_type),
      .rsp_found         (rsp_found)
   );

   // shadow copy of the font tables
   logic [CODE_W-1:0] tab_code [FONTS][ENTRIES];
   logic [TYPE_W-1:0] tab_type [FONTS][ENTRIES];
   bit                tab_set  [FONTS][ENTRIES];
   int                tab_count [FONTS];
   logic [TYPE_W-1:0] tab_dflt [FONTS];
   bit                enc_sjis = 1'b0;

   logic [CODE_W-1:0] hit_codes [FONTS][$];
   rsp_item_type      pending_types [$];
   row_type           dir_rows [$];
   int                errors = 0;
   int                sent_items = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("** kanji_char_type_lookup: FAILED **");
      $finish;
   end

   function automatic logic [CODE_W-1:0] sjis_decode(input logic [CODE_W-1:0] c);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = c[15:8];
      lo = c[7:0];
      if (hi <= 8'h9F) hi = hi - 8'h71;
      else hi = hi - 8'hB1;
      hi = {hi[6:0], 1'b1};
      if (lo > 8'h7F) lo = lo - 8'd1;
      if (lo >= 8'h9E) begin
         lo = lo - 8'h7D;
         hi = hi + 8'd1;
      end else begin
         lo = lo - 8'h1F;
      end
      return {hi, lo};
   endfunction

   function automatic logic [CODE_W-1:0] raw_to_jis(input logic [CODE_W-1:0] c);
      return enc_sjis ? sjis_decode(c) : (c & EUC_MASK);
   endfunction

   // same probe order as the hardware: first, last, then the binary search;
   // safe drops when any probed entry was never written
   function automatic match_type find_char_type(input int f, input logic [CODE_W-1:0] jc);
      match_type m;
      int        n;
      int        lo;
      int        hi;
      int        mid;
      n = tab_count[f];
      m.ctype = tab_dflt[f];
      m.found = 1'b0;
      m.safe  = 1'b1;
      if (n == 0) return m;
      if (!tab_set[f][0] || !tab_set[f][n-1]) begin
         m.safe = 1'b0;
         return m;
      end
      if (jc < tab_code[f][0] || jc > tab_code[f][n-1]) return m;
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (!tab_set[f][mid]) begin
            m.safe = 1'b0;
            return m;
         end
         if (jc < tab_code[f][mid]) hi = mid - 1;
         else if (jc > tab_code[f][mid]) lo = mid + 1;
         else begin
            m.ctype = tab_type[f][mid];
            m.found = 1'b1;
            return m;
         end
      end
      return m;
   endfunction

   // drive one request, wait for its transfer, then update the shadow tables or queue the expected lookup result
   task automatic push_item(input req_item_type it, input bit typed,
                            input rsp_item_type want);
      match_type    m;
      rsp_item_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= it.func;
      req_font_slot   <= it.font;
      req_entry_slot  <= it.slot;
      req_char_code   <= it.code;
      req_type_value  <= it.ctype;
      req_entry_total <= it.total;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      if (it.func != FUNC_UNUSED) sent_items++;
      case (it.func)
         FUNC_LOOKUP: begin
            m = find_char_type(int'(it.font), raw_to_jis(it.code));
            r.ctype = m.ctype;
            r.found = m.found;
            pending_types.push_back(typed ? want : r);
         end
         FUNC_WRITE: begin
            tab_code[it.font][it.slot] = it.code;
            tab_type[it.font][it.slot] = it.ctype;
            tab_set[it.font][it.slot]  = 1'b1;
         end
         FUNC_SETUP: begin
            tab_count[it.font] = (int'(it.total) > ENTRIES) ? ENTRIES : int'(it.total);
            tab_dflt[it.font]  = it.ctype;
         end
         default: ;
      endcase
   endtask

   task automatic set_encoding(input bit sjis);
      req_valid <= 1'b0;
      while (pending_types.size() != 0) @(posedge clock);
      // a write or setup may still be in flight behind the last result
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid         <= 1'b1;
      csr_encoding_mode <= sjis;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      csr_valid <= 1'b0;
      enc_sjis = sjis;
   endtask

   task automatic add_row(input int sjis, input logic [FUNC_W-1:0] func, input int font,
                          input int slot, input int code, input int ctype, input int total,
                          input int typed, input int etype, input int efound);
      row_type w;
      w.sjis        = (sjis != 0);
      w.it.func     = func;
      w.it.font     = FONT_W'(font);
      w.it.slot     = SLOT_W'(slot);
      w.it.code     = CODE_W'(code);
      w.it.ctype    = TYPE_W'(ctype);
      w.it.total    = TOTAL_W'(total);
      w.typed       = (typed != 0);
      w.want.ctype  = TYPE_W'(etype);
      w.want.found  = (efound != 0);
      dir_rows.push_back(w);
   endtask

   function automatic logic [CODE_W-1:0] random_raw_code();
      if (enc_sjis && $urandom_range(4) != 0) begin
         if ($urandom_range(1) == 0) return {8'($urandom_range(8'h81, 8'h9F)),
                                             8'($urandom_range(8'h40, 8'hFC))};
         return {8'($urandom_range(8'hE0, 8'hEF)), 8'($urandom_range(8'h40, 8'hFC))};
      end
      return 16'($urandom_range(16'hFFFF));
   endfunction

   // setup followed by a full set of entry writes, mostly sorted
   task automatic load_table(input int f);
      logic [CODE_W-1:0] jcode [ENTRIES];
      logic [CODE_W-1:0] rawc [ENTRIES];
      logic [CODE_W-1:0] kc;
      logic [CODE_W-1:0] kr;
      req_item_type      it;
      rsp_item_type      none_rsp;
      int                n;
      int                pick;
      int                i;
      int                j;
      pick = $urandom_range(99);
      if (pick < 5) n = 0;
      else if (pick < 85) n = $urandom_range(1, 16);
      else if (pick < 95) n = $urandom_range(17, ENTRIES - 1);
      else n = ENTRIES;
      for (i = 0; i < n; i++) begin
         rawc[i]  = random_raw_code();
         jcode[i] = raw_to_jis(rawc[i]);
         if (i > 0 && $urandom_range(9) == 0) begin
            rawc[i]  = rawc[i-1];
            jcode[i] = jcode[i-1];
         end
      end
      if ($urandom_range(9) != 0) begin
         for (i = 1; i < n; i++) begin
            kc = jcode[i];
            kr = rawc[i];
            j  = i - 1;
            while (j >= 0 && jcode[j] > kc) begin
               jcode[j+1] = jcode[j];
               rawc[j+1]  = rawc[j];
               j--;
            end
            jcode[j+1] = kc;
            rawc[j+1]  = kr;
         end
      end
      it.func  = FUNC_SETUP;
      it.font  = FONT_W'(f);
      it.slot  = SLOT_W'($urandom_range(255));
      it.code  = CODE_W'($urandom_range(16'hFFFF));
      it.ctype = TYPE_W'($urandom_range(255));
      it.total = (n == ENTRIES && $urandom_range(1) == 1) ? TOTAL_W'($urandom_range(257, 511))
                                                          : TOTAL_W'(n);
      push_item(it, 1'b0, none_rsp);
      hit_codes[f].delete();
      for (i = 0; i < n; i++) begin
         it.func  = FUNC_WRITE;
         it.slot  = SLOT_W'(i);
         it.code  = jcode[i];
         it.ctype = TYPE_W'($urandom_range(255));
         it.total = TOTAL_W'($urandom_range(511));
         push_item(it, 1'b0, none_rsp);
         hit_codes[f].push_back(rawc[i]);
      end
   endtask

   task automatic run_phase(input bit sjis, input int idle_pct, input int stall_pct,
                            input int count);
      req_item_type it;
      rsp_item_type none_rsp;
      match_type    m;
      int           target;
      int           pick;
      int           f;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      set_encoding(sjis);
      target = sent_items + count;
      for (f = 0; f < FONTS; f++) load_table(f);
      while (sent_items < target) begin
         pick     = $urandom_range(99);
         f        = $urandom_range(FONTS - 1);
         it.font  = FONT_W'(f);
         it.slot  = SLOT_W'($urandom_range(255));
         it.code  = CODE_W'($urandom_range(16'hFFFF));
         it.ctype = TYPE_W'($urandom_range(255));
         it.total = TOTAL_W'($urandom_range(511));
         if (pick < 8) begin
            load_table(f);
         end else if (pick < 12) begin
            // noise: unused code, stray entry write or stray setup
            case ($urandom_range(2))
               0: it.func = FUNC_UNUSED;
               1: it.func = FUNC_WRITE;
               default: it.func = FUNC_SETUP;
            endcase
            push_item(it, 1'b0, none_rsp);
         end else begin
            it.func = FUNC_LOOKUP;
            pick = $urandom_range(99);
            if (hit_codes[f].size() != 0 && pick < 65) begin
               it.code = hit_codes[f][$urandom_range(hit_codes[f].size() - 1)];
               if (pick >= 50) it.code = it.code ^ 16'h0001;
            end
            m = find_char_type(f, raw_to_jis(it.code));
            if (m.safe) push_item(it, 1'b0, none_rsp);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      rsp_item_type exp_rsp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_types.size() == 0) begin
            $display("%0t: unexpected result char_type=%h found=%b", $time,
                     rsp_char_type, rsp_found);
            errors++;
         end else begin
            exp_rsp = pending_types.pop_front();
            if (rsp_char_type !== exp_rsp.ctype) begin
               $display("%0t: char_type expected %h actual %h", $time, exp_rsp.ctype,
                        rsp_char_type);
               errors++;
            end
            if (rsp_found !== exp_rsp.found) begin
               $display("%0t: found expected %b actual %b", $time, exp_rsp.found,
                        rsp_found);
               errors++;
            end
         end
      end
   end

   initial begin
      rsp_item_type none_rsp;
      int           f;
      for (f = 0; f < FONTS; f++) begin
         tab_count[f] = 0;
         tab_dflt[f]  = '0;
      end
      // sjis func font slot code type total typed exp_type exp_found
      add_row(0, FUNC_LOOKUP, 0, 8'h00, 16'h0000, 8'h00, 0,   1, 8'h00, 0);
      add_row(0, FUNC_LOOKUP, 3, 8'hFF, 16'hFFFF, 8'hFF, 511, 1, 8'h00, 0);
      add_row(0, FUNC_UNUSED, 3, 8'hFF, 16'hFFFF, 8'hFF, 511, 0, 0, 0);
      add_row(0, FUNC_SETUP,  0, 8'h00, 16'h0000, 8'hA5, 3,   0, 0, 0);
      add_row(0, FUNC_WRITE,  0, 8'h00, 16'h0000, 8'hFF, 0,   0, 0, 0);
      add_row(0, FUNC_WRITE,  0, 8'h01, 16'h3021, 8'h11, 0,   0, 0, 0);
      add_row(0, FUNC_WRITE,  0, 8'h02, 16'hFFFF, 8'h80, 0,   0, 0, 0);
      // high bits of each byte are masked off in euc
      add_row(0, FUNC_LOOKUP, 0, 8'h00, 16'h8080, 8'h00, 0,   1, 8'hFF, 1);
      add_row(0, FUNC_LOOKUP, 0, 8'h00, 16'hB0A1, 8'h00, 0,   1, 8'h11, 1);
      add_row(0, FUNC_LOOKUP, 0, 8'h00, 16'h3022, 8'h00, 0,   1, 8'hA5, 0);
      add_row(0, FUNC_LOOKUP, 0, 8'h00, 16'hFFFF, 8'h00, 0,   1, 8'hA5, 0);
      // empty table gives the default
      add_row(0, FUNC_SETUP,  1, 8'h00, 16'h0000, 8'hFF, 0,   0, 0, 0);
      add_row(0, FUNC_LOOKUP, 1, 8'h00, 16'h1234, 8'h00, 0,   1, 8'hFF, 0);
      // unsorted table
      add_row(0, FUNC_SETUP,  2, 8'h00, 16'h0000, 8'h3C, 2,   0, 0, 0);
      add_row(0, FUNC_WRITE,  2, 8'h00, 16'h5000, 8'h01, 0,   0, 0, 0);
      add_row(0, FUNC_WRITE,  2, 8'h01, 16'h4000, 8'h02, 0,   0, 0, 0);
      add_row(0, FUNC_WRITE,  2, 8'hFF, 16'hFFFF, 8'hFF, 0,   0, 0, 0);
      add_row(0, FUNC_LOOKUP, 2, 8'h00, 16'h4000, 8'h00, 0,   0, 0, 0);
      add_row(0, FUNC_LOOKUP, 2, 8'h00, 16'h5000, 8'h00, 0,   0, 0, 0);
      add_row(0, FUNC_LOOKUP, 2, 8'h00, 16'h4800, 8'h00, 0,   0, 0, 0);
      // oversized total saturates
      add_row(0, FUNC_SETUP,  3, 8'h00, 16'h0000, 8'h77, 511, 0, 0, 0);
      // shift-jis, including codes outside the shift-jis range
      add_row(1, FUNC_LOOKUP, 0, 8'h00, 16'h889F, 8'h00, 0,   0, 0, 0);
      add_row(1, FUNC_LOOKUP, 0, 8'h00, 16'h0000, 8'h00, 0,   0, 0, 0);
      add_row(1, FUNC_LOOKUP, 0, 8'h00, 16'hFFFF, 8'h00, 0,   0, 0, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].sjis != enc_sjis) set_encoding(dir_rows[i].sjis);
         push_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
      end

      run_phase(1'b1, 0,  0,  250);
      run_phase(1'b0, 60, 0,  250);
      run_phase(1'b1, 0,  60, 250);
      run_phase(1'b0, 26, 26, 250);

      req_valid <= 1'b0;
      while (pending_types.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("** kanji_char_type_lookup: PASSED **");
      end else begin
         $display("** kanji_char_type_lookup: FAILED **");
      end
      $finish;
   end

endmodule
